// ----- design/mcss_pkg.sv -----
// Shared types and constants for the motion change sample selector.
package mcss_pkg;

  localparam int unsigned SampleSlotsDefault = 16;
  localparam int unsigned QueueDepth         = 2;

  localparam int unsigned ThresholdW = 18;
  localparam int unsigned TimeoutW   = 16;
  localparam int unsigned CfgDataW   = 18;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned DistW      = 18;
  localparam int unsigned SlotOutW   = 4;

  localparam logic [ThresholdW-1:0] ThresholdReset = ThresholdW'(2);
  localparam logic [TimeoutW-1:0]   TimeoutReset   = TimeoutW'(1000);

  typedef enum logic [0:0] {
    CfgThreshold = 1'b0,
    CfgTimeout   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] z;
    logic [TimeW-1:0]  t;
  } sample_t;

  typedef struct packed {
    sample_t smp;
    logic    batch_start;
  } frame_t;

  typedef struct packed {
    logic                stored;
    logic                opened_slot;
    logic [SlotOutW-1:0] slot;
    logic [DistW-1:0]    distance;
  } result_t;

endpackage

// ----- design/motion_change_sample_selector_top.sv -----
// Top level: frame queue, selection core and result queue.
// A pushed frame waits in the frame queue; at its head the selection core decides it
// combinationally when the result queue has room, and the result enters the result queue.
// One frame per cycle while results drain; two-entry queues on both sides absorb stalls.
// Reset (rst_ni low, asynchronous): queues empty, no sample held, slot 0,
// threshold 2 and idle timeout 1000 ms.
module motion_change_sample_selector_top #(
  parameter int unsigned SAMPLE_SLOTS = mcss_pkg::SampleSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  mcss_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [mcss_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [7:0]             accel_x_i,
  input  logic signed [7:0]             accel_y_i,
  input  logic signed [7:0]             accel_z_i,
  input  logic [mcss_pkg::TimeW-1:0]    time_ms_i,
  input  logic                          batch_start_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          stored_o,
  output logic                          opened_slot_o,
  output logic [mcss_pkg::SlotOutW-1:0] slot_o,
  output logic [mcss_pkg::DistW-1:0]    distance_o
);
  import mcss_pkg::*;

  frame_t  frame_in, frame_head;
  result_t result_new, result_head;
  logic    frame_empty, result_full, fire;

  always_comb begin
    frame_in.smp.x       = accel_x_i;
    frame_in.smp.y       = accel_y_i;
    frame_in.smp.z       = accel_z_i;
    frame_in.smp.t       = time_ms_i;
    frame_in.batch_start = batch_start_i;
  end

  mcss_fifo #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (QueueDepth)
  ) u_frame_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (frame_in),
    .full_o  (full),
    .pop_i   (fire),
    .data_o  (frame_head),
    .empty_o (frame_empty)
  );

  assign fire = !frame_empty && !result_full;

  mcss_back #(
    .SAMPLE_SLOTS (SAMPLE_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .frame_i    (frame_head),
    .result_o   (result_new)
  );

  mcss_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QueueDepth)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .data_i  (result_new),
    .full_o  (result_full),
    .pop_i   (pop),
    .data_o  (result_head),
    .empty_o (empty)
  );

  assign stored_o      = result_head.stored;
  assign opened_slot_o = result_head.opened_slot;
  assign slot_o        = result_head.slot;
  assign distance_o    = result_head.distance;

endmodule

// ----- design/mcss_fifo.sv -----
// Small synchronous queue with push/full and pop/empty sides.
module mcss_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = mcss_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count above depth");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_o && empty_o))
    else $error("queue full and empty at once");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_ok && !pop_ok) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");
`endif

endmodule

// ----- design/mcss_back.sv -----
// Selection core: reference tracking, distance, threshold and timeout decision, ring slot.
module mcss_back #(
  parameter int unsigned SAMPLE_SLOTS = mcss_pkg::SampleSlotsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  mcss_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [mcss_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            fire_i,
  input  mcss_pkg::frame_t                frame_i,
  output mcss_pkg::result_t               result_o
);
  import mcss_pkg::*;

  localparam int unsigned SlotW = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(SAMPLE_SLOTS - 1);

  logic [ThresholdW-1:0] thr_q;
  logic [TimeoutW-1:0]   timeout_q;

  sample_t          ref_q, ref_d, last_q, last_d, eff_ref;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             have_any_q, have_any_d;
  logic             follow_q, follow_d, eff_follow;
  logic             sampled_q, sampled_d, eff_sampled;
  logic [DistW-1:0] best_q, best_d, eff_best;

  logic signed [8:0]  dx, dy, dz;
  logic signed [17:0] px, py, pz;
  logic [DistW-1:0]   sq_dist;
  logic [TimeW-1:0]   elapsed;
  logic               motion, idle, stored, opened;

  // A batch start reloads the reference from the last stored sample and resets the batch.
  always_comb begin
    eff_ref     = frame_i.batch_start ? last_q : ref_q;
    eff_sampled = frame_i.batch_start ? 1'b0 : sampled_q;
    eff_follow  = frame_i.batch_start ? 1'b0 : follow_q;
    eff_best    = frame_i.batch_start ? '0 : best_q;
  end

  assign dx = $signed({frame_i.smp.x[7], frame_i.smp.x}) - $signed({eff_ref.x[7], eff_ref.x});
  assign dy = $signed({frame_i.smp.y[7], frame_i.smp.y}) - $signed({eff_ref.y[7], eff_ref.y});
  assign dz = $signed({frame_i.smp.z[7], frame_i.smp.z}) - $signed({eff_ref.z[7], eff_ref.z});
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;
  assign sq_dist = DistW'(px[16:0]) + DistW'(py[16:0]) + DistW'(pz[16:0]);
  assign elapsed = frame_i.smp.t - eff_ref.t;
  assign motion = (sq_dist > thr_q) && (sq_dist > eff_best);
  assign idle   = !eff_sampled && (elapsed > TimeW'(timeout_q));

  always_comb begin
    ref_d      = eff_ref;
    last_d     = last_q;
    slot_d     = slot_q;
    have_any_d = have_any_q;
    follow_d   = eff_follow;
    sampled_d  = eff_sampled;
    best_d     = eff_best;
    stored     = 1'b0;
    opened     = 1'b0;
    if (!have_any_q) begin
      // very first frame: kept as is, reference follows it
      have_any_d = 1'b1;
      follow_d   = 1'b1;
      sampled_d  = 1'b1;
      best_d     = '0;
      last_d     = frame_i.smp;
      ref_d      = frame_i.smp;
      stored     = 1'b1;
    end else if (motion || idle) begin
      if (!eff_sampled) begin
        slot_d    = (slot_q == SlotLast) ? '0 : slot_q + 1'b1;
        sampled_d = 1'b1;
        opened    = 1'b1;
      end
      last_d = frame_i.smp;
      if (eff_follow) begin
        ref_d = frame_i.smp;
      end
      if (sq_dist > eff_best) begin
        best_d = sq_dist;
      end
      stored = 1'b1;
    end
  end

  always_comb begin
    result_o.stored      = stored;
    result_o.opened_slot = opened;
    result_o.slot        = SlotOutW'(slot_d);
    result_o.distance    = have_any_q ? sq_dist : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ThresholdReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgThreshold: thr_q     <= cfg_data_i;
        CfgTimeout:   timeout_q <= cfg_data_i[TimeoutW-1:0];
        default:      thr_q     <= thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q      <= '0;
      last_q     <= '0;
      slot_q     <= '0;
      have_any_q <= 1'b0;
      follow_q   <= 1'b0;
      sampled_q  <= 1'b0;
      best_q     <= '0;
    end else if (fire_i) begin
      ref_q      <= ref_d;
      last_q     <= last_d;
      slot_q     <= slot_d;
      have_any_q <= have_any_d;
      follow_q   <= follow_d;
      sampled_q  <= sampled_d;
      best_q     <= best_d;
    end
  end

`ifndef SYNTHESIS
  a_open_stores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && result_o.opened_slot) |-> result_o.stored)
    else $error("slot opened without a store");
  a_first_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !have_any_q) |->
      (result_o.stored && !result_o.opened_slot && (result_o.distance == '0)))
    else $error("first frame not kept in place");
  a_have_any_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_any_q |=> have_any_q)
    else $error("have_any cleared after a store");
`endif

endmodule

// ----- bench/mcss_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the motion change sample selector: predicts and checks results.
package mcss_tb_pkg;
  import mcss_pkg::*;

  class mcss_scoreboard;
    logic [ThresholdW-1:0] change_thr;
    logic [TimeoutW-1:0]   idle_tmo;
    sample_t               batch_ref;
    sample_t               last_kept;
    logic [SlotOutW-1:0]   ring_slot;
    bit                    any_kept;
    bit                    ref_tracks;
    bit                    batch_has_store;
    logic [DistW-1:0]      best_dist;
    result_t               pending_results[$];
    int                    errors;

    function new();
      change_thr      = ThresholdReset;
      idle_tmo        = TimeoutReset;
      batch_ref       = '0;
      last_kept       = '0;
      ring_slot       = '0;
      any_kept        = 1'b0;
      ref_tracks      = 1'b0;
      batch_has_store = 1'b0;
      best_dist       = '0;
      errors          = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        CfgThreshold: change_thr = value[ThresholdW-1:0];
        CfgTimeout:   idle_tmo   = value[TimeoutW-1:0];
        default: ;
      endcase
    endfunction

    function void keep(sample_t s);
      last_kept = s;
      if (ref_tracks) batch_ref = s;
    endfunction

    // Called once per accepted frame; queues the result it should produce.
    function void note_frame(frame_t f);
      result_t       r;
      int            dx;
      int            dy;
      int            dz;
      logic [TimeW-1:0] elapsed;
      logic [DistW-1:0] d;
      bit            motion;
      bit            idle;
      r = '0;
      d = '0;
      if (f.batch_start) begin
        batch_has_store = 1'b0;
        best_dist       = '0;
        ref_tracks      = 1'b0;
        batch_ref       = last_kept;
      end
      if (!any_kept) begin
        // very first frame: stored in place, no compare
        any_kept        = 1'b1;
        ref_tracks      = 1'b1;
        batch_has_store = 1'b1;
        best_dist       = '0;
        keep(f.smp);
        r.stored = 1'b1;
      end else begin
        dx = int'($signed(f.smp.x)) - int'($signed(batch_ref.x));
        dy = int'($signed(f.smp.y)) - int'($signed(batch_ref.y));
        dz = int'($signed(f.smp.z)) - int'($signed(batch_ref.z));
        d = DistW'(dx * dx + dy * dy + dz * dz);
        elapsed = f.smp.t - batch_ref.t;  // wraps modulo 2^32
        motion = (d > change_thr) && (d > best_dist);
        idle = !batch_has_store && (elapsed > TimeW'(idle_tmo));
        if (motion || idle) begin
          if (!batch_has_store) begin
            ring_slot       = ring_slot + 1'b1;
            batch_has_store = 1'b1;
            r.opened_slot   = 1'b1;
          end
          keep(f.smp);
          if (d > best_dist) best_dist = d;
          r.stored = 1'b1;
        end
      end
      r.slot     = ring_slot;
      r.distance = d;
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.stored !== exp.stored) begin
        $error("stored: expected %0d, actual %0d", exp.stored, got.stored);
        errors++;
      end
      if (got.opened_slot !== exp.opened_slot) begin
        $error("opened_slot: expected %0d, actual %0d", exp.opened_slot, got.opened_slot);
        errors++;
      end
      if (got.slot !== exp.slot) begin
        $error("slot: expected %0d, actual %0d", exp.slot, got.slot);
        errors++;
      end
      if (got.distance !== exp.distance) begin
        $error("distance: expected %0d, actual %0d", exp.distance, got.distance);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top: drives frames and config into the selector, checks every result.
module tb_top;
  import mcss_pkg::*;
  import mcss_tb_pkg::*;

  localparam int unsigned CycleLimit = 500000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_idx_i;
  logic [CfgDataW-1:0]   cfg_data_i;
  logic                  push;
  logic                  full;
  logic signed [7:0]     accel_x_i;
  logic signed [7:0]     accel_y_i;
  logic signed [7:0]     accel_z_i;
  logic [TimeW-1:0]      time_ms_i;
  logic                  batch_start_i;
  logic                  empty;
  logic                  pop;
  logic                  stored_o;
  logic                  opened_slot_o;
  logic [SlotOutW-1:0]   slot_o;
  logic [DistW-1:0]      distance_o;

  mcss_scoreboard        sb;
  bit                    fast_mode;
  logic [TimeW-1:0]      batch_time;
  int unsigned           cur_timeout;

  motion_change_sample_selector_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .time_ms_i     (time_ms_i),
    .batch_start_i (batch_start_i),
    .empty         (empty),
    .pop           (pop),
    .stored_o      (stored_o),
    .opened_slot_o (opened_slot_o),
    .slot_o        (slot_o),
    .distance_o    (distance_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly back-to-back (always in fast mode), some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (fast_mode || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic int near_axis(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v;
  endfunction

  task automatic send_frame(int x, int y, int z, logic [TimeW-1:0] t, bit bs);
    frame_t f;
    int     gap;
    f.smp.x       = 8'(x);
    f.smp.y       = 8'(y);
    f.smp.z       = 8'(z);
    f.smp.t       = t;
    f.batch_start = bs;
    accel_x_i     <= 8'(x);
    accel_y_i     <= 8'(y);
    accel_z_i     <= 8'(z);
    time_ms_i     <= t;
    batch_start_i <= bs;
    push          <= 1'b1;
    do @(posedge clk_i); while (full);
    sb.note_frame(f);
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off the sender until every queued result has been popped
  task automatic drain_results();
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(logic [ThresholdW-1:0] thr, logic [TimeoutW-1:0] tmo);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgThreshold;
    cfg_data_i <= CfgDataW'(thr);
    @(posedge clk_i);
    sb.write_reg(CfgThreshold, CfgDataW'(thr));
    cfg_idx_i  <= CfgTimeout;
    cfg_data_i <= CfgDataW'(tmo);
    @(posedge clk_i);
    sb.write_reg(CfgTimeout, CfgDataW'(tmo));
    cfg_we_i   <= 1'b0;
    cur_timeout = 32'(tmo);
  endtask

  task automatic run_phase(int n, logic [ThresholdW-1:0] thr, logic [TimeoutW-1:0] tmo,
                           bit fast);
    int sent;
    int len;
    int sel;
    int spread;
    int bx;
    int by;
    int bz;
    write_config(thr, tmo);
    fast_mode = fast;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 49) == 0) drain_results();
      if ($urandom_range(0, 9) == 0) begin
        // noise: anything goes, including stray batch marks and time jumps
        send_frame(int'($urandom_range(0, 255)) - 128, int'($urandom_range(0, 255)) - 128,
                   int'($urandom_range(0, 255)) - 128, $urandom(),
                   1'($urandom_range(0, 1)));
        sent++;
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 7) batch_time = batch_time + $urandom_range(0, 2 * cur_timeout + 2);
        else if (sel < 9) batch_time = batch_time + cur_timeout + $urandom_range(0, 1);
        else batch_time = $urandom();
        case ($urandom_range(0, 4))
          0: spread = 1;
          1: spread = 3;
          2: spread = 12;
          3: spread = 50;
          default: spread = 255;
        endcase
        bx = int'($urandom_range(0, 255)) - 128;
        by = int'($urandom_range(0, 255)) - 128;
        bz = int'($urandom_range(0, 255)) - 128;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_frame(near_axis(bx, spread), near_axis(by, spread), near_axis(bz, spread),
                     batch_time, i == 0);
          sent++;
        end
      end
    end
    drain_results();
  endtask

  // result side: random pop stalls, check on every popped transaction
  initial begin
    result_t got;
    int      stall;
    stall = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        got.stored      = stored_o;
        got.opened_slot = opened_slot_o;
        got.slot        = slot_o;
        got.distance    = distance_o;
        sb.check_result(got);
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    fast_mode   = 1'b0;
    batch_time  = '0;
    cur_timeout = 32'(TimeoutReset);
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgThreshold;
    cfg_data_i    <= '0;
    push          <= 1'b0;
    accel_x_i     <= '0;
    accel_y_i     <= '0;
    accel_z_i     <= '0;
    time_ms_i     <= '0;
    batch_start_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset config (threshold 2, timeout 1000)
    send_frame(-128, -128, -128, 32'hFFFF_FF00, 1'b0);  // first frame, no batch mark
    send_frame(127, 127, 127, 32'hFFFF_FF00, 1'b0);     // max distance, ref follows
    send_frame(127, 127, 127, 32'hFFFF_FF00, 1'b0);
    send_frame(127, 127, 126, 32'h0000_00F0, 1'b1);     // timer wrap, below threshold
    send_frame(126, 126, 127, 32'h0000_00F0, 1'b0);     // equal to threshold
    send_frame(125, 127, 127, 32'h0000_00F0, 1'b0);     // opens a slot
    send_frame(124, 127, 127, 32'h0000_00F0, 1'b0);     // beats best in batch
    send_frame(126, 127, 127, 32'h0000_00F0, 1'b0);
    send_frame(124, 127, 127, 32'h0000_04D9, 1'b1);     // idle store, 1001 ms
    send_frame(124, 127, 127, 32'h0000_04D9, 1'b0);
    send_frame(124, 127, 127, 32'h0000_08C1, 1'b1);     // exactly at timeout
    send_frame(-128, -128, -128, 32'h0000_08C1, 1'b0);
    send_frame(0, 0, 0, 32'h0000_08C1, 1'b0);
    send_frame(85, -86, 85, 32'hAAAA_5555, 1'b1);
    send_frame(-86, 85, -86, 32'h5555_AAAA, 1'b1);
    send_frame(0, 0, 0, 32'h0000_0000, 1'b1);
    send_frame(127, -128, 0, 32'h0000_0000, 1'b1);
    send_frame(-1, 1, -1, 32'hFFFF_FFFF, 1'b0);
    drain_results();

    run_phase(180, ThresholdW'(0), TimeoutW'(0), 1'b0);
    run_phase(180, ThresholdW'(195075), TimeoutW'(65535), 1'b0);
    run_phase(180, ThresholdReset, TimeoutReset, 1'b0);
    run_phase(180, ThresholdW'($urandom_range(0, 3000)), TimeoutW'($urandom_range(0, 4000)),
              1'b0);
    run_phase(180, ThresholdW'($urandom_range(0, 195075)), TimeoutW'($urandom_range(0, 65535)),
              1'b0);
    run_phase(180, ThresholdW'(20), TimeoutW'(200), 1'b1);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
